// ===== rtl/i2crm_pkg.sv =====
// shared types and constants of the i2c register master
`default_nettype none

package i2crm_pkg;

    // bus phase codes of the transaction sequencer
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RS_LOW    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START_A   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_START_B   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_START_C   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_BIT_LOW   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_BIT_HIGH  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_LOW    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_NACK_LOW  = 4'd11;
    localparam logic [PHASE_W-1:0] PH_NACK_HIGH = 4'd12;
    localparam logic [PHASE_W-1:0] PH_STOP_A    = 4'd13;
    localparam logic [PHASE_W-1:0] PH_STOP_B    = 4'd14;
    localparam logic [PHASE_W-1:0] PH_STOP_C    = 4'd15;

    // request mode codes
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // byte steps of a transaction after each acknowledge
    localparam logic [2:0] STEP_ADDR = 3'd0;
    localparam logic [2:0] STEP_REG  = 3'd1;
    localparam logic [2:0] STEP_DATA = 3'd2;

    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic [7:0] TIMEOUT_RESET = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       mode;
        logic       is_read;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] read_data;
        logic       cmd_rejected;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/i2crm_intf.sv =====
// request and result channel interfaces of the i2c register master
`default_nettype none

interface i2crm_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       is_read;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (
        output valid, mode, is_read, device_address, register_address, write_data, sda_in,
        input  ready
    );
    modport sink (
        input  valid, mode, is_read, device_address, register_address, write_data, sda_in,
        output ready
    );
endinterface

interface i2crm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
    logic       cmd_rejected;

    modport source (
        output valid, scl_out, sda_out, busy_res, done_res, ack_error, read_data,
               cmd_rejected,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, done_res, ack_error, read_data,
               cmd_rejected,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/i2crm_in_stage.sv =====
// input register stage holding one accepted request
`default_nettype none

module i2crm_in_stage
    import i2crm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2crm_req_if.sink  i_req,
    input  wire logic  i_advance,
    output logic       o_valid,
    output t_req       o_item
);

    logic r_valid;
    logic n_valid;
    t_req r_item;

    // take a request whenever the stage is empty or draining this cycle
    assign i_req.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_req.valid && i_req.ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.mode             <= i_req.mode;
            r_item.is_read          <= i_req.is_read;
            r_item.device_address   <= i_req.device_address;
            r_item.register_address <= i_req.register_address;
            r_item.write_data       <= i_req.write_data;
            r_item.sda_in           <= i_req.sda_in;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/i2crm_sequencer.sv =====
// transaction state and one-phase-per-tick next-state logic
`default_nettype none

module i2crm_sequencer
    import i2crm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_advance,
    input  wire t_req       i_item,
    output t_res            o_res
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [3:0]         r_bit_count, n_bit_count;
    logic [7:0]         r_shift, n_shift;
    logic [2:0]         r_step, n_step;
    logic [7:0]         r_wait, n_wait;
    logic               r_is_read, n_is_read;
    logic [6:0]         r_dev, n_dev;
    logic [7:0]         r_reg, n_reg;
    logic [7:0]         r_dat, n_dat;
    logic [7:0]         r_rx, n_rx;
    logic [1:0]         r_lines, n_lines;
    logic               r_err, n_err;
    logic [7:0]         r_timeout;
    logic               n_done;
    logic               n_rej;

    // next state for the request in the input register
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_step      = r_step;
        n_wait      = r_wait;
        n_is_read   = r_is_read;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_dat       = r_dat;
        n_rx        = r_rx;
        n_lines     = r_lines;
        n_err       = r_err;
        n_done      = 1'b0;
        n_rej       = 1'b0;

        if (i_item.mode == MODE_CMD) begin
            if (r_phase != PH_IDLE) begin
                n_rej = 1'b1;
            end else begin
                n_is_read   = i_item.is_read;
                n_dev       = i_item.device_address;
                n_reg       = i_item.register_address;
                n_dat       = i_item.write_data;
                n_err       = 1'b0;
                n_step      = STEP_ADDR;
                n_bit_count = 4'd0;
                n_wait      = 8'd0;
                n_phase     = PH_START_A;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_RS_LOW: begin
                    n_lines = 2'b01;
                    n_phase = PH_START_A;
                end
                PH_START_A: begin
                    n_lines = 2'b11;
                    n_phase = PH_START_B;
                end
                PH_START_B: begin
                    n_lines = 2'b10;
                    n_phase = PH_START_C;
                end
                PH_START_C: begin
                    n_lines     = 2'b00;
                    n_shift     = {r_dev, (r_step != STEP_ADDR)};
                    n_bit_count = 4'd0;
                    n_phase     = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    n_lines = {1'b0, (r_shift & MSB_MASK) != 8'd0};
                    n_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    n_lines     = {1'b1, r_lines[0]};
                    n_shift     = {r_shift[6:0], 1'b0};
                    n_bit_count = r_bit_count + 4'd1;
                    n_phase     = (n_bit_count >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
                end
                PH_ACK_LOW: begin
                    n_lines = 2'b01;
                    n_wait  = 8'd0;
                    n_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    n_lines = 2'b11;
                    if (!i_item.sda_in) begin
                        // acknowledged: pick the next byte of the transaction
                        n_step = r_step + 3'd1;
                        if (n_step == STEP_REG) begin
                            n_shift     = r_reg;
                            n_bit_count = 4'd0;
                            n_phase     = PH_BIT_LOW;
                        end else if (!r_is_read) begin
                            if (n_step == STEP_DATA) begin
                                n_shift     = r_dat;
                                n_bit_count = 4'd0;
                                n_phase     = PH_BIT_LOW;
                            end else begin
                                n_phase = PH_STOP_A;
                            end
                        end else if (n_step == STEP_DATA) begin
                            n_phase = PH_RS_LOW;
                        end else begin
                            n_shift     = 8'd0;
                            n_bit_count = 4'd0;
                            n_phase     = PH_RD_LOW;
                        end
                    end else if (r_wait >= r_timeout) begin
                        n_err   = 1'b1;
                        n_phase = PH_STOP_A;
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end
                PH_RD_LOW: begin
                    n_lines = 2'b01;
                    n_phase = PH_RD_HIGH;
                end
                PH_RD_HIGH: begin
                    n_lines     = 2'b11;
                    n_shift     = {r_shift[6:0], i_item.sda_in};
                    n_bit_count = r_bit_count + 4'd1;
                    n_phase     = (n_bit_count >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RD_LOW;
                end
                PH_NACK_LOW: begin
                    n_lines = 2'b01;
                    n_phase = PH_NACK_HIGH;
                end
                PH_NACK_HIGH: begin
                    n_lines = 2'b11;
                    n_phase = PH_STOP_A;
                end
                PH_STOP_A: begin
                    n_lines = 2'b00;
                    n_phase = PH_STOP_B;
                end
                PH_STOP_B: begin
                    n_lines = 2'b10;
                    n_phase = PH_STOP_C;
                end
                PH_STOP_C: begin
                    n_lines = 2'b11;
                    if (!r_err && r_is_read) begin
                        n_rx = r_shift;
                    end
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    // result fields as seen after this request
    always_comb begin
        o_res.scl_out      = n_lines[1];
        o_res.sda_out      = n_lines[0];
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = n_done;
        o_res.ack_error    = n_err;
        o_res.read_data    = n_rx;
        o_res.cmd_rejected = n_rej;
    end

    // ack timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // sequencer state, updated as each request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_step      <= STEP_ADDR;
            r_wait      <= 8'd0;
            r_is_read   <= 1'b0;
            r_dev       <= 7'd0;
            r_reg       <= 8'd0;
            r_dat       <= 8'd0;
            r_rx        <= 8'd0;
            r_lines     <= 2'b11;
            r_err       <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_step      <= n_step;
            r_wait      <= n_wait;
            r_is_read   <= n_is_read;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_dat       <= n_dat;
            r_rx        <= n_rx;
            r_lines     <= n_lines;
            r_err       <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/i2c_register_master_unit.sv =====
// top level of the i2c register master: input stage, sequencer, result register
//
// Usage:
//   i_req carries requests. mode 0 is a command (is_read, device_address,
//   register_address, write_data) that starts a register write or read when
//   the master is idle; mode 1 is a bus tick that moves SCL/SDA on by one
//   phase, with sda_in the sampled data line.
//   o_res gives exactly one result per request: the line levels to drive,
//   busy, a done pulse, the ack error flag, the last read byte and whether a
//   command was turned away because a transaction was running.
//   i_cfg_we/i_cfg_wdata write the ack timeout (reset 250); write only idle.
// Timing:
//   one request per cycle while o_res is not held off. A request is taken into
//   the input register, the sequencer settles state and result from it and
//   the result register loads them once it is free; o_res is driven from
//   that register.
// Reset:
//   synchronous; both lines released high, sequencer idle, both stages empty.
// Stall:
//   while o_res is held off the result register keeps its value, the input
//   register fills and i_req.ready drops; nothing is dropped or repeated.
`default_nettype none

module i2c_register_master_unit
    import i2crm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    i2crm_req_if.sink       i_req,
    i2crm_res_if.source     o_res
);

    logic in_valid;
    t_req in_item;
    t_res seq_res;
    logic advance;
    logic r_out_valid;
    t_res r_out;

    // move the held request on when the result register is free
    assign advance = in_valid && (!r_out_valid || o_res.ready);

    i2crm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    i2crm_sequencer u_sequencer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_item      (in_item),
        .o_res       (seq_res)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.scl_out      = r_out.scl_out;
    assign o_res.sda_out      = r_out.sda_out;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.done_res     = r_out.done_res;
    assign o_res.ack_error    = r_out.ack_error;
    assign o_res.read_data    = r_out.read_data;
    assign o_res.cmd_rejected = r_out.cmd_rejected;

endmodule

`default_nettype wire

// ===== rtl/i2crm_checker.sv =====
// port-level assertions of the i2c register master and their bind
`default_nettype none

module i2crm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_res_valid,
    input wire logic i_res_ready,
    input wire logic i_busy,
    input wire logic i_done,
    input wire logic i_rejected
);

    // a pending result stays offered until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a finished transaction leaves the master idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done |-> !i_busy)
        else $error("done reported while busy");

    // a command is only turned away during a transaction
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_rejected |-> i_busy && !i_done)
        else $error("command rejected while idle");

endmodule

bind i2c_register_master_unit i2crm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_busy      (o_res.busy_res),
    .i_done      (o_res.done_res),
    .i_rejected  (o_res.cmd_rejected)
);

`default_nettype wire
